>>> rtl/core/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

    // square root unit: 34-bit radicand, one root bit per stage
    localparam int RAD_W  = 34;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int SQ_LAT = ROOT_W;

    // divider unit: quotient below 2^QUO_W, one quotient bit per stage
    localparam int QUO_W   = 32;
    localparam int DEN_W   = 35;
    localparam int NUM_W   = DEN_W + QUO_W;
    localparam int DIV_LAT = QUO_W;

    // field widths
    localparam int GAIN_W  = 18;
    localparam int SCALE_W = 22;
    localparam int FORCE_W = 22;

    // register map, word index
    localparam logic [1:0] REG_APPROACH   = 2'd0;
    localparam logic [1:0] REG_SEPARATION = 2'd1;
    localparam logic [1:0] REG_SCALE      = 2'd2;

    localparam logic [GAIN_W-1:0]  APPROACH_RST   = GAIN_W'(13107);
    localparam logic [GAIN_W-1:0]  SEPARATION_RST = GAIN_W'(65536);
    localparam logic [SCALE_W-1:0] SCALE_RST      = SCALE_W'(786432);

    // stiffness clamp, Q16
    localparam int STIFF_HI = 58982;
    localparam int STIFF_LO = -19661;

    // stages: input, products, dot/miss, root, den, sat check, two
    // dividers, curve, stiffness, ratio setup, divider, five force steps,
    // divider
    localparam int PIPE_LAT = 3 + SQ_LAT + 2 + DIV_LAT + 3 + DIV_LAT + 5 + DIV_LAT;

endpackage

>>> rtl/core/scp_sqrt.sv
`timescale 1ns / 1ps

module scp_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [scp_pkg::RAD_W-1:0]   i_rad,
    output logic [scp_pkg::ROOT_W-1:0]  o_root
);
    import scp_pkg::*;

    logic [REM_W-1:0]  r_rem  [SQ_LAT];
    logic [ROOT_W-1:0] r_root [SQ_LAT];
    logic [RAD_W-1:0]  r_bits [SQ_LAT];

    // restoring digit recurrence, two radicand bits per stage
    for (genvar j = 0; j < SQ_LAT; j++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  bits_in;
        logic [REM_W+1:0]  part;
        logic [REM_W+1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  n_rem;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign bits_in = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign bits_in = r_bits[j-1];
        end

        assign part  = {rem_in, bits_in[RAD_W-1 -: 2]};
        assign trial = (REM_W+2)'({root_in, 2'b01});
        assign ge    = part >= trial;
        assign n_rem = ge ? REM_W'(part - trial) : REM_W'(part);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= {root_in[ROOT_W-2:0], ge};
                r_bits[j] <= {bits_in[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQ_LAT-1];

endmodule

>>> rtl/core/scp_div.sv
`timescale 1ns / 1ps

module scp_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [scp_pkg::NUM_W-1:0]  i_num,
    input  logic [scp_pkg::DEN_W-1:0]  i_den,
    output logic [scp_pkg::QUO_W-1:0]  o_quo
);
    import scp_pkg::*;

    // needs i_num >> QUO_W below i_den, else quotient is garbage
    logic [DEN_W-1:0] r_rem [DIV_LAT];
    logic [DEN_W-1:0] r_den [DIV_LAT];
    logic [QUO_W-1:0] r_low [DIV_LAT];
    logic [QUO_W-1:0] r_quo [DIV_LAT];

    for (genvar j = 0; j < DIV_LAT; j++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   part;
        logic             ge;
        logic [DEN_W-1:0] n_rem;

        if (j == 0) begin : g_first
            assign rem_in = i_num[NUM_W-1:QUO_W];
            assign den_in = i_den;
            assign low_in = i_num[QUO_W-1:0];
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign low_in = r_low[j-1];
            assign quo_in = r_quo[j-1];
        end

        assign part  = {rem_in, low_in[QUO_W-1]};
        assign ge    = part >= {1'b0, den_in};
        assign n_rem = ge ? DEN_W'(part - {1'b0, den_in}) : part[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_den[j] <= den_in;
                r_low[j] <= {low_in[QUO_W-2:0], 1'b0};
                r_quo[j] <= {quo_in[QUO_W-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];

endmodule

>>> rtl/core/soft_contact_pair_force_top.sv
`timescale 1ns / 1ps

// Soft contact force for one candidate pair of circular cells per request.
// Input channel: i_valid / o_stall with positions, radii, relative
// velocities and the pass mode; a request is taken when i_valid is high and
// o_stall is low. Output channel: o_valid / i_stall with o_contact and the
// saturated force on cell a (cell b gets the negation).
// From acceptance to o_valid: 3 setup stages, a 17-stage square root,
// the dist * sum_r and speed saturation stages, a 32-stage divider bank
// for r and closing speed, 3 curve/stiffness stages, a 32-stage divider
// for the ratio, 5 force stages, a 32-stage force divider bank and the
// output register. One request per cycle while o_stall is low; the
// bit-per-stage dividers and the root set the depth, not the rate.
// Configuration goes through the APB port: approach gain at 0x0,
// separation gain at 0x4, force scale at 0x8; write only while idle.
// Reset (synchronous, active low) empties the pipe and loads the default
// gains. When the receiver stalls, the finished result sits in the output
// register; the pipe keeps moving into bubbles and only backs up into
// o_stall once a valid request reaches the last stage.
module soft_contact_pair_force_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // request channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_mode,
    input  logic signed [31:0]               i_position_a_x,
    input  logic signed [31:0]               i_position_a_y,
    input  logic signed [31:0]               i_position_b_x,
    input  logic signed [31:0]               i_position_b_y,
    input  logic [15:0]                      i_radius_a,
    input  logic [15:0]                      i_radius_b,
    input  logic signed [31:0]               i_relative_velocity_x,
    input  logic signed [31:0]               i_relative_velocity_y,
    input  logic signed [31:0]               i_relative_predicted_x,
    input  logic signed [31:0]               i_relative_predicted_y,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_contact,
    output logic signed [scp_pkg::FORCE_W-1:0] o_force_x,
    output logic signed [scp_pkg::FORCE_W-1:0] o_force_y
);
    import scp_pkg::*;

    typedef struct packed {
        logic               miss;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic [16:0]        adx;
        logic [16:0]        ady;
        logic [16:0]        sum_r;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } t_s0;

    typedef struct packed {
        logic               miss;
        logic               sx;
        logic               sy;
        logic [16:0]        adx;
        logic [16:0]        ady;
        logic [16:0]        sum_r;
        logic [34:0]        sqr;
        logic [33:0]        srsq;
        logic signed [49:0] px;
        logic signed [49:0] py;
    } t_s1;

    typedef struct packed {
        logic        miss;
        logic        sx;
        logic        sy;
        logic [16:0] adx;
        logic [16:0] ady;
        logic [16:0] sum_r;
        logic [50:0] mag;
        logic        vneg;
    } t_s2;

    typedef struct packed {
        logic        miss;
        logic        sx;
        logic        sy;
        logic [16:0] adx;
        logic [16:0] ady;
        logic [16:0] sum_r;
        logic [50:0] mag;
        logic        vneg;
        logic [16:0] dlen;
        logic [33:0] den;
        logic        vsat;
    } t_sb;

    typedef struct packed {
        logic               miss;
        logic               sx;
        logic               sy;
        logic [16:0]        adx;
        logic [16:0]        ady;
        logic [16:0]        sum_r;
        logic [16:0]        dlen;
        logic [16:0]        r;
        logic signed [52:0] pa;
        logic signed [52:0] pb;
        logic [31:0]        vsq;
        logic signed [18:0] kd;
        logic               vlt0;
        logic               vlt1;
    } t_sc;

    typedef struct packed {
        logic               miss;
        logic               sx;
        logic               sy;
        logic [16:0]        adx;
        logic [16:0]        ady;
        logic [16:0]        sum_r;
        logic [16:0]        dlen;
        logic [16:0]        r;
        logic signed [17:0] k;
    } t_sd;

    typedef struct packed {
        logic        miss;
        logic        sx;
        logic        sy;
        logic [16:0] adx;
        logic [16:0] ady;
        logic [16:0] sum_r;
        logic [16:0] dlen;
        logic [33:0] num;
        logic [34:0] den2;
    } t_se;

    typedef struct packed {
        logic               miss;
        logic               sx;
        logic               sy;
        logic [16:0]        adx;
        logic [16:0]        ady;
        logic [16:0]        sum_r;
        logic [16:0]        dlen;
        logic [FORCE_W-1:0] f;
    } t_sf;

    typedef struct packed {
        logic               miss;
        logic               sx;
        logic               sy;
        logic [16:0]        dlen;
        logic [FORCE_W-1:0] f;
        logic [33:0]        amx;
        logic [33:0]        amy;
    } t_sg;

    typedef struct packed {
        logic        miss;
        logic        sx;
        logic        sy;
        logic [16:0] dlen;
        logic [38:0] plx;
        logic [38:0] phx;
        logic [38:0] ply;
        logic [38:0] phy;
    } t_sh;

    typedef struct packed {
        logic        miss;
        logic        sx;
        logic        sy;
        logic [16:0] dlen;
        logic [55:0] magx;
        logic [55:0] magy;
    } t_si;

    typedef struct packed {
        logic        miss;
        logic        sx;
        logic        sy;
        logic        satx;
        logic        saty;
        logic [16:0] dlen;
        logic [55:0] magx;
        logic [55:0] magy;
    } t_sj;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [GAIN_W-1:0]  r_approach_gain;
    logic [GAIN_W-1:0]  r_separation_gain;
    logic [SCALE_W-1:0] r_force_scale;
    logic               cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_approach_gain   <= APPROACH_RST;
            r_separation_gain <= SEPARATION_RST;
            r_force_scale     <= SCALE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_APPROACH:   r_approach_gain   <= pwdata[GAIN_W-1:0];
                REG_SEPARATION: r_separation_gain <= pwdata[GAIN_W-1:0];
                REG_SCALE:      r_force_scale     <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_APPROACH:   prdata = 32'(r_approach_gain);
            REG_SEPARATION: prdata = 32'(r_separation_gain);
            REG_SCALE:      prdata = 32'(r_force_scale);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // flow control: whole pipe steps together; it holds only when a valid
    // result is at the tail and the output register is full and stalled
    // ---------------------------------------------------------------
    logic                r_vld [PIPE_LAT];
    logic                r_out_valid;
    logic                en;

    assign en      = !(r_vld[PIPE_LAT-1] && r_out_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_LAT; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < PIPE_LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // ---------------------------------------------------------------
    // S0: deltas, box test, velocity select
    // ---------------------------------------------------------------
    logic signed [32:0] s0_dx, s0_dy, s0_svx, s0_svy;
    logic [32:0]        s0_adx, s0_ady;
    logic [16:0]        s0_sum;
    t_s0                n_s0, r_s0;

    always_comb begin
        s0_dx  = 33'(i_position_a_x) - 33'(i_position_b_x);
        s0_dy  = 33'(i_position_a_y) - 33'(i_position_b_y);
        s0_adx = s0_dx[32] ? 33'(-s0_dx) : 33'(s0_dx);
        s0_ady = s0_dy[32] ? 33'(-s0_dy) : 33'(s0_dy);
        s0_sum = {1'b0, i_radius_a} + {1'b0, i_radius_b};
        // corrective pass: mean of current and predicted, floored
        s0_svx = 33'(i_relative_velocity_x) + 33'(i_relative_predicted_x);
        s0_svy = 33'(i_relative_velocity_y) + 33'(i_relative_predicted_y);

        n_s0.miss  = (s0_adx > 33'(s0_sum)) || (s0_ady > 33'(s0_sum));
        n_s0.dx    = s0_dx[17:0];
        n_s0.dy    = s0_dy[17:0];
        n_s0.adx   = s0_adx[16:0];
        n_s0.ady   = s0_ady[16:0];
        n_s0.sum_r = s0_sum;
        n_s0.vx    = i_mode ? s0_svx[32:1] : i_relative_velocity_x;
        n_s0.vy    = i_mode ? s0_svy[32:1] : i_relative_velocity_y;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_s0 <= n_s0;
    end

    // ---------------------------------------------------------------
    // S1: squares and velocity products
    // ---------------------------------------------------------------
    t_s1 n_s1, r_s1;

    always_comb begin
        n_s1.miss  = r_s0.miss;
        n_s1.sx    = r_s0.dx[17];
        n_s1.sy    = r_s0.dy[17];
        n_s1.adx   = r_s0.adx;
        n_s1.ady   = r_s0.ady;
        n_s1.sum_r = r_s0.sum_r;
        n_s1.sqr   = 35'(r_s0.adx) * 35'(r_s0.adx) + 35'(r_s0.ady) * 35'(r_s0.ady);
        n_s1.srsq  = 34'(r_s0.sum_r) * 34'(r_s0.sum_r);
        n_s1.px    = 50'(r_s0.vx) * 50'(r_s0.dx);
        n_s1.py    = 50'(r_s0.vy) * 50'(r_s0.dy);
    end

    always_ff @(posedge i_clk) begin
        if (en) r_s1 <= n_s1;
    end

    // ---------------------------------------------------------------
    // S2: circle test, dot product magnitude
    // ---------------------------------------------------------------
    logic signed [50:0] s2_dot;
    logic [33:0]        r_sqr;
    t_s2                n_s2, r_s2;

    always_comb begin
        s2_dot      = 51'(r_s1.px) + 51'(r_s1.py);
        n_s2.miss   = r_s1.miss || (r_s1.sqr == '0) || (r_s1.sqr > 35'(r_s1.srsq));
        n_s2.sx     = r_s1.sx;
        n_s2.sy     = r_s1.sy;
        n_s2.adx    = r_s1.adx;
        n_s2.ady    = r_s1.ady;
        n_s2.sum_r  = r_s1.sum_r;
        n_s2.mag    = s2_dot[50] ? 51'(-s2_dot) : 51'(s2_dot);
        n_s2.vneg   = s2_dot[50];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2  <= n_s2;
            r_sqr <= r_s1.sqr[33:0];
        end
    end

    // ---------------------------------------------------------------
    // distance
    // ---------------------------------------------------------------
    logic [ROOT_W-1:0] sq_dist;
    t_s2               r_d1 [SQ_LAT];

    scp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_sqr),
        .o_root (sq_dist)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[0] <= r_s2;
            for (int i = 1; i < SQ_LAT; i++) r_d1[i] <= r_d1[i-1];
        end
    end

    // ---------------------------------------------------------------
    // Sa: dist * sum_r;  Sb: closing speed saturation check
    // ---------------------------------------------------------------
    t_sb n_sa, r_sa, n_sb, r_sb;

    always_comb begin
        n_sa.miss  = r_d1[SQ_LAT-1].miss;
        n_sa.sx    = r_d1[SQ_LAT-1].sx;
        n_sa.sy    = r_d1[SQ_LAT-1].sy;
        n_sa.adx   = r_d1[SQ_LAT-1].adx;
        n_sa.ady   = r_d1[SQ_LAT-1].ady;
        n_sa.sum_r = r_d1[SQ_LAT-1].sum_r;
        n_sa.mag   = r_d1[SQ_LAT-1].mag;
        n_sa.vneg  = r_d1[SQ_LAT-1].vneg;
        n_sa.dlen  = sq_dist;
        n_sa.den   = 34'(sq_dist) * 34'(r_d1[SQ_LAT-1].sum_r);
        n_sa.vsat  = 1'b0;

        n_sb       = r_sa;
        // speed of 2^32 or more in Q16 already pins the stiffness clamp
        n_sb.vsat  = r_sa.mag >= 51'({r_sa.den, 16'b0});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa <= n_sa;
            r_sb <= n_sb;
        end
    end

    // ---------------------------------------------------------------
    // r = dist / sum_r and v = dot / (dist * sum_r), both Q16
    // ---------------------------------------------------------------
    logic [QUO_W-1:0] q_r, q_v;
    t_sb              r_d2 [DIV_LAT];

    scp_div u_div_r (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NUM_W'({r_sb.dlen, 16'b0})),
        .i_den (DEN_W'(r_sb.sum_r)),
        .o_quo (q_r)
    );

    scp_div u_div_v (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NUM_W'({r_sb.mag, 16'b0})),
        .i_den (DEN_W'(r_sb.den)),
        .o_quo (q_v)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2[0] <= r_sb;
            for (int i = 1; i < DIV_LAT; i++) r_d2[i] <= r_d2[i-1];
        end
    end

    // ---------------------------------------------------------------
    // Sc: damping curve products
    // ---------------------------------------------------------------
    logic [32:0]        sc_vmag;
    logic signed [33:0] sc_v;
    t_sc                n_sc, r_sc;

    always_comb begin
        sc_vmag = r_d2[DIV_LAT-1].vsat ? {1'b1, 32'b0} : {1'b0, q_v};
        sc_v    = r_d2[DIV_LAT-1].vneg ? -$signed({1'b0, sc_vmag})
                                       : $signed({1'b0, sc_vmag});

        n_sc.miss  = r_d2[DIV_LAT-1].miss;
        n_sc.sx    = r_d2[DIV_LAT-1].sx;
        n_sc.sy    = r_d2[DIV_LAT-1].sy;
        n_sc.adx   = r_d2[DIV_LAT-1].adx;
        n_sc.ady   = r_d2[DIV_LAT-1].ady;
        n_sc.sum_r = r_d2[DIV_LAT-1].sum_r;
        n_sc.dlen  = r_d2[DIV_LAT-1].dlen;
        n_sc.r     = q_r[16:0];
        n_sc.pa    = 53'($signed({1'b0, r_approach_gain})) * 53'(sc_v);
        n_sc.pb    = 53'($signed({1'b0, r_separation_gain})) * 53'(sc_v);
        n_sc.vsq   = 32'(sc_v[15:0]) * 32'(sc_v[15:0]);
        n_sc.kd    = $signed({1'b0, r_separation_gain}) - $signed({1'b0, r_approach_gain});
        n_sc.vlt0  = sc_v[33];
        n_sc.vlt1  = (sc_v[33:16] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) r_sc <= n_sc;
    end

    // ---------------------------------------------------------------
    // Sd: pick curve segment, clamp, stiffness k = -vf
    // ---------------------------------------------------------------
    logic signed [71:0] sd_mid, sd_vneg, sd_vmid, sd_vhi, sd_vf, sd_vc;
    t_sd                n_sd, r_sd;

    always_comb begin
        sd_mid  = (72'(r_sc.pa) <<< 17) + 72'(r_sc.kd) * 72'($signed({1'b0, r_sc.vsq}));
        sd_vneg = 72'(r_sc.pa) >>> 16;
        sd_vmid = sd_mid >>> 33;
        sd_vhi  = (72'(r_sc.pb) - (72'(r_sc.kd) <<< 15)) >>> 16;

        if (r_sc.vlt0)      sd_vf = sd_vneg;
        else if (r_sc.vlt1) sd_vf = sd_vmid;
        else                sd_vf = sd_vhi;

        if (sd_vf > 72'(STIFF_HI))      sd_vc = 72'(STIFF_HI);
        else if (sd_vf < 72'(STIFF_LO)) sd_vc = 72'(STIFF_LO);
        else                            sd_vc = sd_vf;

        n_sd.miss  = r_sc.miss;
        n_sd.sx    = r_sc.sx;
        n_sd.sy    = r_sc.sy;
        n_sd.adx   = r_sc.adx;
        n_sd.ady   = r_sc.ady;
        n_sd.sum_r = r_sc.sum_r;
        n_sd.dlen  = r_sc.dlen;
        n_sd.r     = r_sc.r;
        n_sd.k     = 18'(-sd_vc);
    end

    always_ff @(posedge i_clk) begin
        if (en) r_sd <= n_sd;
    end

    // ---------------------------------------------------------------
    // Se: ratio numerator r(1-k) and denominator 1 - k(2r-1)
    // ---------------------------------------------------------------
    logic signed [18:0] se_t, se_omk;
    logic signed [36:0] se_kt, se_den;
    t_se                n_se, r_se;

    always_comb begin
        se_t   = $signed({1'b0, r_sd.r, 1'b0}) - 19'sd65536;
        se_kt  = 37'(r_sd.k) * 37'(se_t);
        se_den = 37'sh1_0000_0000 - se_kt;
        se_omk = 19'sd65536 - 19'(r_sd.k);

        n_se.miss  = r_sd.miss;
        n_se.sx    = r_sd.sx;
        n_se.sy    = r_sd.sy;
        n_se.adx   = r_sd.adx;
        n_se.ady   = r_sd.ady;
        n_se.sum_r = r_sd.sum_r;
        n_se.dlen  = r_sd.dlen;
        n_se.num   = 34'(r_sd.r) * 34'(se_omk[16:0]);
        n_se.den2  = se_den[34:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) r_se <= n_se;
    end

    logic [QUO_W-1:0] q_ratio;
    t_se              r_d3 [DIV_LAT];

    scp_div u_div_ratio (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NUM_W'({r_se.num, 16'b0})),
        .i_den (DEN_W'(r_se.den2)),
        .o_quo (q_ratio)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3[0] <= r_se;
            for (int i = 1; i < DIV_LAT; i++) r_d3[i] <= r_d3[i-1];
        end
    end

    // ---------------------------------------------------------------
    // Sf: f = (1 - ratio) * scale;  Sg: |delta| * sum_r
    // Sh: split products;  Si: sum;  Sj: saturation check
    // ---------------------------------------------------------------
    logic [16:0] sf_s;
    logic [38:0] sf_prod;
    t_sf         n_sf, r_sf;
    t_sg         n_sg, r_sg;
    t_sh         n_sh, r_sh;
    t_si         n_si, r_si;
    t_sj         n_sj, r_sj;

    always_comb begin
        sf_s    = 17'(18'd65536 - q_ratio[17:0]);
        sf_prod = 39'(sf_s) * 39'(r_force_scale);

        n_sf.miss  = r_d3[DIV_LAT-1].miss;
        n_sf.sx    = r_d3[DIV_LAT-1].sx;
        n_sf.sy    = r_d3[DIV_LAT-1].sy;
        n_sf.adx   = r_d3[DIV_LAT-1].adx;
        n_sf.ady   = r_d3[DIV_LAT-1].ady;
        n_sf.sum_r = r_d3[DIV_LAT-1].sum_r;
        n_sf.dlen  = r_d3[DIV_LAT-1].dlen;
        n_sf.f     = sf_prod[37:16];

        n_sg.miss = r_sf.miss;
        n_sg.sx   = r_sf.sx;
        n_sg.sy   = r_sf.sy;
        n_sg.dlen = r_sf.dlen;
        n_sg.f    = r_sf.f;
        n_sg.amx  = 34'(r_sf.adx) * 34'(r_sf.sum_r);
        n_sg.amy  = 34'(r_sf.ady) * 34'(r_sf.sum_r);

        n_sh.miss = r_sg.miss;
        n_sh.sx   = r_sg.sx;
        n_sh.sy   = r_sg.sy;
        n_sh.dlen = r_sg.dlen;
        n_sh.plx  = 39'(r_sg.amx[16:0]) * 39'(r_sg.f);
        n_sh.phx  = 39'(r_sg.amx[33:17]) * 39'(r_sg.f);
        n_sh.ply  = 39'(r_sg.amy[16:0]) * 39'(r_sg.f);
        n_sh.phy  = 39'(r_sg.amy[33:17]) * 39'(r_sg.f);

        n_si.miss = r_sh.miss;
        n_si.sx   = r_sh.sx;
        n_si.sy   = r_sh.sy;
        n_si.dlen = r_sh.dlen;
        n_si.magx = 56'(r_sh.plx) + {r_sh.phx, 17'b0};
        n_si.magy = 56'(r_sh.ply) + {r_sh.phy, 17'b0};

        // quotient of 2^22 or more saturates either sign
        n_sj.miss = r_si.miss;
        n_sj.sx   = r_si.sx;
        n_sj.sy   = r_si.sy;
        n_sj.dlen = r_si.dlen;
        n_sj.magx = r_si.magx;
        n_sj.magy = r_si.magy;
        n_sj.satx = r_si.magx >= 56'({r_si.dlen, 38'b0});
        n_sj.saty = r_si.magy >= 56'({r_si.dlen, 38'b0});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sf <= n_sf;
            r_sg <= n_sg;
            r_sh <= n_sh;
            r_si <= n_si;
            r_sj <= n_sj;
        end
    end

    // ---------------------------------------------------------------
    // force magnitude / (dist << 16)
    // ---------------------------------------------------------------
    logic [QUO_W-1:0] q_fx, q_fy;
    t_sj              r_d4 [DIV_LAT];

    scp_div u_div_fx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NUM_W'(r_sj.magx)),
        .i_den (DEN_W'({r_sj.dlen, 16'b0})),
        .o_quo (q_fx)
    );

    scp_div u_div_fy (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NUM_W'(r_sj.magy)),
        .i_den (DEN_W'({r_sj.dlen, 16'b0})),
        .o_quo (q_fy)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d4[0] <= r_sj;
            for (int i = 1; i < DIV_LAT; i++) r_d4[i] <= r_d4[i-1];
        end
    end

    // ---------------------------------------------------------------
    // sign, saturate, miss gating, output register
    // ---------------------------------------------------------------
    localparam logic [QUO_W-1:0] POS_LIM = QUO_W'((1 << (FORCE_W - 1)) - 1);
    localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1 << (FORCE_W - 1));

    logic signed [FORCE_W-1:0] fo_x, fo_y;
    logic                      r_out_contact;
    logic signed [FORCE_W-1:0] r_out_fx, r_out_fy;

    always_comb begin
        if (r_d4[DIV_LAT-1].sx) begin
            if (r_d4[DIV_LAT-1].satx || q_fx > NEG_LIM) fo_x = -FORCE_W'(NEG_LIM);
            else                                        fo_x = -FORCE_W'(q_fx);
        end else begin
            if (r_d4[DIV_LAT-1].satx || q_fx > POS_LIM) fo_x = FORCE_W'(POS_LIM);
            else                                        fo_x = FORCE_W'(q_fx);
        end
        if (r_d4[DIV_LAT-1].sy) begin
            if (r_d4[DIV_LAT-1].saty || q_fy > NEG_LIM) fo_y = -FORCE_W'(NEG_LIM);
            else                                        fo_y = -FORCE_W'(q_fy);
        end else begin
            if (r_d4[DIV_LAT-1].saty || q_fy > POS_LIM) fo_y = FORCE_W'(POS_LIM);
            else                                        fo_y = FORCE_W'(q_fy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= r_vld[PIPE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out_contact <= !r_d4[DIV_LAT-1].miss;
            r_out_fx      <= r_d4[DIV_LAT-1].miss ? '0 : fo_x;
            r_out_fy      <= r_d4[DIV_LAT-1].miss ? '0 : fo_y;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_contact = r_out_contact;
    assign o_force_x = r_out_fx;
    assign o_force_y = r_out_fy;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall && r_vld[PIPE_LAT-1]))
        else $error("input stalled without a blocked result");

    a_take_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted request lost at pipe entry");

    a_tail_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_LAT-1] && !o_stall) |=> o_valid)
        else $error("tail result not moved to output");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_contact) |-> (o_force_x == '0 && o_force_y == '0))
        else $error("force on a pair without contact");

endmodule
